>>> hw/rtl/osbfa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package osbfa_pkg;

  // field widths
  localparam int SYM_W      = 10;
  localparam int TYPE_W     = 8;
  localparam int PRICE_W    = 24;
  localparam int QTY_W      = 32;
  localparam int AMT_W      = PRICE_W + QTY_W;
  localparam int VOL_W      = 48;
  localparam int TOTAL_W    = 64;
  localparam int BIN_W      = 4;
  localparam int KIND_W     = 3;
  localparam int KINDS      = 3;

  // stream packing
  localparam int IN_DATA_W  = 192;
  localparam int OUT_DATA_W = 72;

  // edge registers
  localparam int EDGE_W     = 56;
  localparam int NUM_EDGES  = 8;
  localparam int EDGE_IDX_W = 3;
  localparam int CFG_IDX_W  = 4;

  localparam logic OP_RECORD  = 1'b0;
  localparam logic OP_READOUT = 1'b1;

  localparam logic [TYPE_W-1:0] FILL_CODE = 8'h46;

  localparam logic [KIND_W-1:0] KIND_BUY_VOL  = 3'd0;
  localparam logic [KIND_W-1:0] KIND_SELL_VOL = 3'd1;
  localparam logic [KIND_W-1:0] KIND_BOTH_VOL = 3'd2;
  localparam logic [KIND_W-1:0] KIND_BUY_AMT  = 3'd3;
  localparam logic [KIND_W-1:0] KIND_SELL_AMT = 3'd4;
  localparam logic [KIND_W-1:0] KIND_BOTH_AMT = 3'd5;

  typedef logic [NUM_EDGES-1:0][EDGE_W-1:0] edge_arr_t;

  localparam edge_arr_t EDGE_RESET = {
    56'd1000000000, 56'd500000000, 56'd200000000, 56'd100000000,
    56'd50000000,   56'd20000000,  56'd10000000,  56'd5000000
  };

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_BIN,
    ST_RMW,
    ST_DUMP
  } state_t;

  typedef struct packed {
    logic             buy_hit;
    logic [BIN_W-1:0] buy_bin;
    logic             sell_hit;
    logic [BIN_W-1:0] sell_bin;
  } bin_res_t;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [BIN_W-1:0]   bin;
    logic [TOTAL_W-1:0] total;
    logic               last;
  } out_beat_t;

endpackage

`default_nettype wire

>>> hw/rtl/osbfa_binner.sv
`timescale 1ns / 1ps
`default_nettype none

module osbfa_binner import osbfa_pkg::*; #(
  parameter int NUM_BINS = 9
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [PRICE_W-1:0] trade_price,
  input  logic [QTY_W-1:0]   trade_qty,
  input  logic [PRICE_W-1:0] bid_price,
  input  logic [QTY_W-1:0]   bid_qty,
  input  logic [PRICE_W-1:0] offer_price,
  input  logic [QTY_W-1:0]   offer_qty,
  input  edge_arr_t          edges,
  output logic               done,
  output logic [AMT_W-1:0]   trade_amt,
  output bin_res_t           res
);

  logic               busy_r;
  logic [1:0]         step_r;
  logic               done_r;
  logic [AMT_W-1:0]   prod_r;
  logic [AMT_W-1:0]   amt_r;
  bin_res_t           res_r;
  logic [PRICE_W-1:0] op_a;
  logic [QTY_W-1:0]   op_b;
  logic [NUM_BINS-1:0] ge;
  logic               hit;
  logic [BIN_W-1:0]   bin;

  // one shared multiplier: trade, then bid, then offer
  always_comb begin
    unique case (step_r)
      2'd0: begin
        op_a = trade_price;
        op_b = trade_qty;
      end
      2'd1: begin
        op_a = bid_price;
        op_b = bid_qty;
      end
      default: begin
        op_a = offer_price;
        op_b = offer_qty;
      end
    endcase
  end

  // first bin whose range holds the product, else the open top bin
  always_comb begin
    ge[0] = 1'b1;
    for (int j = 1; j < NUM_BINS; j++) begin
      ge[j] = (prod_r >= edges[j-1]);
    end
    bin = BIN_W'(NUM_BINS - 1);
    for (int d = NUM_BINS - 2; d >= 0; d--) begin
      if (ge[d] && !ge[d+1]) bin = BIN_W'(d);
    end
    hit = (prod_r != '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= 2'd0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= 2'd0;
      end else if (busy_r) begin
        step_r <= step_r + 2'd1;
        if (step_r == 2'd3) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (busy_r) begin
      prod_r <= {{QTY_W{1'b0}}, op_a} * {{PRICE_W{1'b0}}, op_b};
      unique case (step_r)
        2'd1: amt_r <= prod_r;
        2'd2: begin
          res_r.buy_hit <= hit;
          res_r.buy_bin <= bin;
        end
        2'd3: begin
          res_r.sell_hit <= hit;
          res_r.sell_bin <= bin;
        end
        default: ;
      endcase
    end
  end

  assign done      = done_r;
  assign trade_amt = amt_r;
  assign res       = res_r;

endmodule

`default_nettype wire

>>> hw/rtl/osbfa_bank.sv
`timescale 1ns / 1ps
`default_nettype none

module osbfa_bank import osbfa_pkg::*; #(
  parameter int DEPTH  = 27648,
  parameter int ADDR_W = 15
) (
  input  logic               clk,
  input  logic               rd_en,
  input  logic [ADDR_W-1:0]  rd_addr,
  input  logic               wr_en,
  input  logic [ADDR_W-1:0]  wr_addr,
  input  logic [VOL_W-1:0]   wr_vol,
  input  logic [TOTAL_W-1:0] wr_amt,
  output logic [VOL_W-1:0]   rd_vol,
  output logic [TOTAL_W-1:0] rd_amt
);

  logic [VOL_W-1:0]   vol_mem [0:DEPTH-1];
  logic [TOTAL_W-1:0] amt_mem [0:DEPTH-1];
  logic [VOL_W-1:0]   rd_vol_r;
  logic [TOTAL_W-1:0] rd_amt_r;

  // read-first on a same-address collision
  always_ff @(posedge clk) begin
    if (wr_en) begin
      vol_mem[wr_addr] <= wr_vol;
      amt_mem[wr_addr] <= wr_amt;
    end
    if (rd_en) begin
      rd_vol_r <= vol_mem[rd_addr];
      rd_amt_r <= amt_mem[rd_addr];
    end
  end

  assign rd_vol = rd_vol_r;
  assign rd_amt = rd_amt_r;

endmodule

`default_nettype wire

>>> hw/rtl/osbfa_out_q.sv
`timescale 1ns / 1ps
`default_nettype none

module osbfa_out_q import osbfa_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  out_beat_t push_beat,
  input  logic      ready,
  output logic      valid,
  output out_beat_t beat,
  output logic [1:0] count
);

  out_beat_t  slot_r [0:1];
  logic       wp_r;
  logic       rp_r;
  logic [1:0] cnt_r;
  logic       pop;

  assign pop = (cnt_r != 2'd0) && ready;

  always_ff @(posedge clk) begin
    if (push) slot_r[wp_r] <= push_beat;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop)  rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

  assign valid = (cnt_r != 2'd0);
  assign beat  = slot_r[rp_r];
  assign count = cnt_r;

endmodule

`default_nettype wire

>>> hw/rtl/order_size_bin_flow_accumulator.sv
// trade flow: a trade is accepted, passes through the shared multiplier and binner, and then
//   through three read-modify-writes; the next beat is taken only after that sequence ends
// throughput: a dropped item (not a fill, order invalid, symbol out of range) is discarded
//   without leaving idle; a readout gives 54 beats at one per cycle while out_tready
//   stays high, bounded by the single read port of the totals memories
// reset: synchronous active-low rst_n; edges return to their defaults, then a clearing pass
//   over all NUM_SYMBOLS*3*NUM_BINS entries (27648 by default) zeroes the totals, in_tready low
`timescale 1ns / 1ps
`default_nettype none

module order_size_bin_flow_accumulator import osbfa_pkg::*; #(
  parameter int NUM_SYMBOLS = 1024,
  parameter int NUM_BINS    = 9
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // in_tdata, lowest bit up: symbol[9:0], trade_type[17:10], trade_price[41:18],
  // trade_qty[73:42], bid_ok[74], bid_price[98:75], bid_total_qty[130:99],
  // offer_ok[131], offer_price[155:132], offer_total_qty[187:156], zero pad
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic                  in_tuser,     // opcode
  // out_tdata, lowest bit up: bin_index[3:0], total[67:4], zero pad
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic [KIND_W-1:0]     out_tuser,    // stat_kind
  output logic                  out_tlast,    // last
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [EDGE_W-1:0]     cfg_data
);

  localparam int SLOTS  = KINDS * NUM_BINS;
  localparam int DEPTH  = NUM_SYMBOLS * SLOTS;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int SLOT_W = $clog2(SLOTS);
  localparam logic [ADDR_W-1:0] NB_A = ADDR_W'(NUM_BINS);

  // input beat fields
  logic [SYM_W-1:0]   in_sym;
  logic [TYPE_W-1:0]  in_type;
  logic [PRICE_W-1:0] in_tprice;
  logic [QTY_W-1:0]   in_tqty;
  logic               in_bok;
  logic [PRICE_W-1:0] in_bprice;
  logic [QTY_W-1:0]   in_bqty;
  logic               in_ook;
  logic [PRICE_W-1:0] in_oprice;
  logic [QTY_W-1:0]   in_oqty;

  assign in_sym    = in_tdata[9:0];
  assign in_type   = in_tdata[17:10];
  assign in_tprice = in_tdata[41:18];
  assign in_tqty   = in_tdata[73:42];
  assign in_bok    = in_tdata[74];
  assign in_bprice = in_tdata[98:75];
  assign in_bqty   = in_tdata[130:99];
  assign in_ook    = in_tdata[131];
  assign in_oprice = in_tdata[155:132];
  assign in_oqty   = in_tdata[187:156];

  state_t state_r, state_nxt;

  edge_arr_t edge_r;

  // captured trade
  logic [ADDR_W-1:0]  base_r;
  logic [PRICE_W-1:0] tprice_r, bprice_r, oprice_r;
  logic [QTY_W-1:0]   tqty_r, bqty_r, oqty_r;

  // clearing pass and read-modify-write sequencing
  logic [ADDR_W-1:0] clr_r;
  logic [1:0]        u_r;
  logic              wen_r;
  logic [ADDR_W-1:0] waddr_r;

  // readout walk: pass 0 reads volumes, pass 1 reads amounts and clears
  logic              pass_r;
  logic [1:0]        kk_r;
  logic [BIN_W-1:0]  b_r;
  logic [SLOT_W-1:0] slot_r;

  // tag of the read in flight
  logic              tag_valid_r;
  logic              tag_amt_r;
  logic [KIND_W-1:0] tag_kind_r;
  logic [BIN_W-1:0]  tag_bin_r;
  logic              tag_last_r;

  logic acc, sym_ok, is_fill, go_rec, go_dump;
  logic bin_done;
  logic [AMT_W-1:0] trade_amt;
  bin_res_t bres;

  logic               rd_en, wr_en;
  logic [ADDR_W-1:0]  rd_addr, wr_addr;
  logic [VOL_W-1:0]   wr_vol, rd_vol, vol_sat;
  logic [TOTAL_W-1:0] wr_amt, rd_amt, amt_sat;
  logic [VOL_W:0]     vol_sum;
  logic [TOTAL_W:0]   amt_sum;

  logic              rmw_en;
  logic [ADDR_W-1:0] rmw_addr;
  logic [ADDR_W-1:0] dump_addr;
  logic              last_slot;
  logic [KIND_W-1:0] dump_kind;
  logic              issue;
  logic [2:0]        occ;
  logic [1:0]        q_count;
  logic              q_pop;
  out_beat_t         push_beat, q_beat;

  // item decode
  assign acc     = in_tvalid && in_tready;
  assign sym_ok  = (17'(in_sym) < 17'(NUM_SYMBOLS));
  assign is_fill = (in_type == FILL_CODE) && in_bok && in_ook;
  assign go_rec  = acc && sym_ok && (in_tuser == OP_RECORD) && is_fill;
  assign go_dump = acc && sym_ok && (in_tuser == OP_READOUT);

  // edge registers, writes past the list are dropped
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      edge_r <= EDGE_RESET;
    end else if (cfg_valid && cfg_ready && (cfg_index < CFG_IDX_W'(NUM_EDGES))) begin
      edge_r[cfg_index[EDGE_IDX_W-1:0]] <= cfg_data;
    end
  end

  osbfa_binner #(
    .NUM_BINS (NUM_BINS)
  ) u_binner (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (go_rec),
    .trade_price (tprice_r),
    .trade_qty   (tqty_r),
    .bid_price   (bprice_r),
    .bid_qty     (bqty_r),
    .offer_price (oprice_r),
    .offer_qty   (oqty_r),
    .edges       (edge_r),
    .done        (bin_done),
    .trade_amt   (trade_amt),
    .res         (bres)
  );

  osbfa_bank #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_bank (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_vol  (wr_vol),
    .wr_amt  (wr_amt),
    .rd_vol  (rd_vol),
    .rd_amt  (rd_amt)
  );

  // saturating accumulate on the word read in the previous cycle
  assign vol_sum = {1'b0, rd_vol} + {{(VOL_W + 1 - QTY_W){1'b0}}, tqty_r};
  assign amt_sum = {1'b0, rd_amt} + {{(TOTAL_W + 1 - AMT_W){1'b0}}, trade_amt};
  assign vol_sat = vol_sum[VOL_W] ? {VOL_W{1'b1}} : vol_sum[VOL_W-1:0];
  assign amt_sat = amt_sum[TOTAL_W] ? {TOTAL_W{1'b1}} : amt_sum[TOTAL_W-1:0];

  // update slots: buy bin, sell bin, both bin when the two bins agree
  always_comb begin
    unique case (u_r)
      2'd0: begin
        rmw_en   = bres.buy_hit;
        rmw_addr = base_r + ADDR_W'(bres.buy_bin);
      end
      2'd1: begin
        rmw_en   = bres.sell_hit;
        rmw_addr = base_r + NB_A + ADDR_W'(bres.sell_bin);
      end
      2'd2: begin
        rmw_en   = bres.buy_hit && bres.sell_hit && (bres.buy_bin == bres.sell_bin);
        rmw_addr = base_r + NB_A + NB_A + ADDR_W'(bres.buy_bin);
      end
      default: begin
        rmw_en   = 1'b0;
        rmw_addr = base_r;
      end
    endcase
  end

  assign dump_addr = base_r + ADDR_W'(slot_r);
  assign last_slot = (slot_r == SLOT_W'(SLOTS - 1));
  assign dump_kind = pass_r ? (KIND_BUY_AMT + {1'b0, kk_r}) : {1'b0, kk_r};

  // room in the output queue, counting the read in flight
  assign q_pop = out_tvalid && out_tready;
  assign occ   = {1'b0, q_count} + {2'b0, tag_valid_r} - {2'b0, q_pop};

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (clr_r == ADDR_W'(DEPTH - 1)) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        priority if (go_rec)  state_nxt = ST_BIN;
        else if (go_dump)     state_nxt = ST_DUMP;
        else                  state_nxt = ST_IDLE;
      end
      ST_BIN: begin
        if (bin_done) state_nxt = ST_RMW;
      end
      ST_RMW: begin
        if (u_r == 2'd3) state_nxt = ST_IDLE;
      end
      ST_DUMP: begin
        if (issue && last_slot && pass_r) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  // memory and handshake controls
  always_comb begin
    in_tready = 1'b0;
    issue     = 1'b0;
    rd_en     = 1'b0;
    rd_addr   = rmw_addr;
    wr_en     = 1'b0;
    wr_addr   = waddr_r;
    wr_vol    = vol_sat;
    wr_amt    = amt_sat;
    unique case (state_r)
      ST_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_r;
        wr_vol  = '0;
        wr_amt  = '0;
      end
      ST_IDLE: begin
        in_tready = 1'b1;
      end
      ST_RMW: begin
        rd_en = rmw_en;
        wr_en = wen_r;
      end
      ST_DUMP: begin
        issue   = (occ < 3'd2);
        rd_en   = issue;
        rd_addr = dump_addr;
        // second pass zeroes each entry as it is read
        wr_en   = issue && pass_r;
        wr_addr = dump_addr;
        wr_vol  = '0;
        wr_amt  = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      u_r         <= 2'd0;
      wen_r       <= 1'b0;
      pass_r      <= 1'b0;
      kk_r        <= 2'd0;
      b_r         <= '0;
      slot_r      <= '0;
      tag_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      tag_valid_r <= issue;
      wen_r       <= (state_r == ST_RMW) && rd_en;
      if (state_r == ST_CLEAR) clr_r <= clr_r + ADDR_W'(1);
      if (state_r == ST_BIN) u_r <= 2'd0;
      else if (state_r == ST_RMW) u_r <= u_r + 2'd1;
      if (go_dump) begin
        pass_r <= 1'b0;
        kk_r   <= 2'd0;
        b_r    <= '0;
        slot_r <= '0;
      end else if (issue) begin
        if (last_slot) begin
          pass_r <= 1'b1;
          kk_r   <= 2'd0;
          b_r    <= '0;
          slot_r <= '0;
        end else begin
          slot_r <= slot_r + SLOT_W'(1);
          if (b_r == BIN_W'(NUM_BINS - 1)) begin
            b_r  <= '0;
            kk_r <= kk_r + 2'd1;
          end else begin
            b_r <= b_r + BIN_W'(1);
          end
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (acc) begin
      base_r   <= ADDR_W'(32'(in_sym) * 32'(SLOTS));
      tprice_r <= in_tprice;
      tqty_r   <= in_tqty;
      bprice_r <= in_bprice;
      bqty_r   <= in_bqty;
      oprice_r <= in_oprice;
      oqty_r   <= in_oqty;
    end
    waddr_r    <= rd_addr;
    tag_amt_r  <= pass_r;
    tag_kind_r <= dump_kind;
    tag_bin_r  <= b_r;
    tag_last_r <= pass_r && last_slot;
  end

  assign push_beat.kind  = tag_kind_r;
  assign push_beat.bin   = tag_bin_r;
  assign push_beat.total = tag_amt_r ? rd_amt : {{(TOTAL_W - VOL_W){1'b0}}, rd_vol};
  assign push_beat.last  = tag_last_r;

  osbfa_out_q u_out_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (tag_valid_r),
    .push_beat (push_beat),
    .ready     (out_tready),
    .valid     (out_tvalid),
    .beat      (q_beat),
    .count     (q_count)
  );

  assign out_tdata = {{(OUT_DATA_W - TOTAL_W - BIN_W){1'b0}}, q_beat.total, q_beat.bin};
  assign out_tuser = q_beat.kind;
  assign out_tlast = q_beat.last;

endmodule

`default_nettype wire

>>> hw/rtl/osbfa_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module osbfa_checker import osbfa_pkg::*; #(
  parameter int NUM_BINS = 9
) (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tready,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata,
  input logic [KIND_W-1:0]     out_tuser,
  input logic                  out_tlast
);

  // a stalled output beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) &&
      $stable(out_tuser) && $stable(out_tlast))
    else $error("output beat changed while stalled");

  // reset empties the output queue and starts the clearing pass
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && !in_tready)
    else $error("block not quiet after reset");

  // the closing beat of a readout is the both-amount total of the top bin
  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |->
      out_tuser == KIND_BOTH_AMT && out_tdata[BIN_W-1:0] == BIN_W'(NUM_BINS - 1))
    else $error("last beat on wrong total");

  // only six kinds of total exist
  a_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tuser != 3'd6 && out_tuser != 3'd7 &&
      out_tdata[BIN_W-1:0] < BIN_W'(NUM_BINS))
    else $error("kind or bin out of range");

endmodule

bind order_size_bin_flow_accumulator osbfa_checker #(
  .NUM_BINS (NUM_BINS)
) u_osbfa_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);

`default_nettype wire
